// ===== design/rgh_pkg.sv =====
// shared constants and types for the run-gap histogram block
// no dependencies; imported by run_gap_histogram
`default_nettype none

package rgh_pkg;

  // sizing of the block
  localparam int MAX_RUN      = 5;
  localparam int NUM_BINS     = 32;
  localparam int NUM_SEGMENTS = 2;
  localparam int COUNT_WIDTH  = 16;

  localparam int HIST_DEPTH = NUM_SEGMENTS * MAX_RUN * NUM_BINS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SEG_W      = $clog2(NUM_SEGMENTS + 1);
  localparam int RUN_CNT_W  = $clog2(MAX_RUN + 2);
  localparam int RUN_IDX_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  localparam logic [15:0] SEG_LEN_RESET = 16'd2000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // operation codes carried on tuser
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // work handed from the stream stage to the memory stage
  typedef struct packed {
    logic               inc;     // increment the addressed bin
    logic               rd;      // read transaction, produces a result
    logic               rd_ok;   // read address is inside the histogram
    logic [HIST_AW-1:0] addr;
  } mem_op_t;

endpackage

`default_nettype wire

// ===== design/rgh_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rgh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/run_gap_histogram.sv =====
// run-gap histogram top level: stream tracking, histogram memory and read-out
// depends on rgh_pkg and rgh_ram
//
// The block takes a byte stream cut into segments of segment_length bytes and
// finds maximal runs of equal bytes of exact length 1 to 5 that touch neither
// the first nor the last byte of their segment. For every run length it
// counts the gap since the previous such run into a saturating 16-bit bin
// (32 bins per run length and segment, two segments, larger gaps dropped).
// A transaction with tuser = 1 reads one bin and returns one result
// transaction; a transaction with tuser = 0 pushes one byte and returns
// nothing. Bytes after the second segment are ignored. One transaction is
// taken every clock cycle while s_axis_tready is high; a read result passes
// through the input register, the memory read and the result register in
// turn. Increments are read-modify-write on a one-read, one-write
// memory, with the last write forwarded so that back-to-back hits on the
// same bin count correctly. After reset the histogram memory is cleared one
// entry a cycle over all 320 entries, during which s_axis_tready stays low.
// cfg writes land at the next edge and act on the stream stage at once, so
// they must only be made while no transaction is in flight. A result that
// cannot leave is held in the result register and a second one is parked in
// a one-entry skid register; apart from the clearing pass, only while that
// skid register is full does s_axis_tready drop and the whole pipeline
// stall, so s_axis_tready never depends combinationally on m_axis_tready.
`default_nettype none

module run_gap_histogram
  import rgh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: segment_length
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // symbol[7:0], segment_select[8],
                                          // run_length_select[11:9],
                                          // bin_select[16:12], zero pad
  input  wire logic        s_axis_tuser,  // operation
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata   // bin_count
);

  // --------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------
  logic adv;          // every stage moves one step
  logic clr_active;
  logic [HIST_AW-1:0] clr_addr;
  logic        skid_valid;  // second result parked behind a waiting one
  logic [15:0] skid_data;

  assign adv           = !skid_valid;
  assign s_axis_tready = adv && !clr_active;

  // --------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------
  logic [15:0] seg_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= SEG_LEN_RESET;
    end else if (cfg_wr_en) begin
      seg_len <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------
  // stage a: registered input transaction
  // --------------------------------------------------------------------
  logic       a_valid;
  op_t        a_op;
  logic [7:0] a_sym;
  logic       a_seg;
  logic [2:0] a_rl;
  logic [4:0] a_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid && s_axis_tready;
    end
    if (adv) begin
      a_op  <= op_t'(s_axis_tuser);
      a_sym <= s_axis_tdata[7:0];
      a_seg <= s_axis_tdata[8];
      a_rl  <= s_axis_tdata[11:9];
      a_bin <= s_axis_tdata[16:12];
    end
  end

  // --------------------------------------------------------------------
  // stream state: run tracking per segment
  // --------------------------------------------------------------------
  logic [7:0]           cur_byte,  cur_byte_next;
  logic [15:0]          run_start, run_start_next;
  logic [RUN_CNT_W-1:0] run_cnt,   run_cnt_next;
  logic [15:0]          pos,       pos_next;
  logic [SEG_W-1:0]     seg_idx,   seg_idx_next;
  logic [15:0]          prev_start      [MAX_RUN];
  logic [15:0]          prev_start_next [MAX_RUN];
  mem_op_t              b_op, b_op_next;

  logic                 close_ok;
  logic [RUN_IDX_W-1:0] len_idx;
  logic [15:0]          prev_sel;
  logic [15:0]          gap;
  logic [15:0]          pos_inc;
  logic                 seg_end;

  // close-out of the run that ends before the current byte
  assign close_ok = (run_start != 16'd0) && (run_cnt != '0)
                    && (32'(run_cnt) <= MAX_RUN);
  assign len_idx  = RUN_IDX_W'(run_cnt - RUN_CNT_W'(1));
  assign prev_sel = prev_start[len_idx];
  assign gap      = run_start - prev_sel - 16'd1;
  assign pos_inc  = pos + 16'd1;
  // a length of zero stands for 65536, reached when the position wraps
  assign seg_end  = (pos_inc == 16'd0) || ((seg_len != 16'd0) && (pos_inc >= seg_len));

  always_comb begin
    cur_byte_next   = cur_byte;
    run_start_next  = run_start;
    run_cnt_next    = run_cnt;
    pos_next        = pos;
    seg_idx_next    = seg_idx;
    prev_start_next = prev_start;
    b_op_next       = '0;

    if (a_valid && (a_op == OP_READ)) begin
      b_op_next.rd    = 1'b1;
      b_op_next.rd_ok = (32'(a_seg) < NUM_SEGMENTS) && (a_rl != 3'd0)
                        && (32'(a_rl) <= MAX_RUN) && (32'(a_bin) < NUM_BINS);
      b_op_next.addr  = HIST_AW'(a_seg) * HIST_AW'(MAX_RUN * NUM_BINS)
                        + HIST_AW'(a_rl - 3'd1) * HIST_AW'(NUM_BINS)
                        + HIST_AW'(a_bin);
    end else if (a_valid && (32'(seg_idx) < NUM_SEGMENTS)) begin
      if (pos == 16'd0) begin
        cur_byte_next  = a_sym;
        run_start_next = 16'd0;
        run_cnt_next   = RUN_CNT_W'(1);
      end else if (a_sym == cur_byte) begin
        // saturate one above the longest counted run
        if (32'(run_cnt) <= MAX_RUN) begin
          run_cnt_next = run_cnt + RUN_CNT_W'(1);
        end
      end else begin
        if (close_ok) begin
          prev_start_next[len_idx] = run_start;
          // a run at position one has no earlier run and records nothing
          if ((run_start > prev_sel) && (32'(gap) < NUM_BINS)) begin
            b_op_next.inc  = 1'b1;
            b_op_next.addr = HIST_AW'(seg_idx) * HIST_AW'(MAX_RUN * NUM_BINS)
                             + HIST_AW'(len_idx) * HIST_AW'(NUM_BINS)
                             + HIST_AW'(gap);
          end
        end
        cur_byte_next  = a_sym;
        run_start_next = pos;
        run_cnt_next   = RUN_CNT_W'(1);
      end

      if (seg_end) begin
        // a run still open at the last byte is dropped
        pos_next       = 16'd0;
        seg_idx_next   = seg_idx + SEG_W'(1);
        run_start_next = 16'd0;
        run_cnt_next   = '0;
        for (int r = 0; r < MAX_RUN; r++) begin
          prev_start_next[r] = 16'd1;
        end
      end else begin
        pos_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_byte  <= 8'd0;
      run_start <= 16'd0;
      run_cnt   <= '0;
      pos       <= 16'd0;
      seg_idx   <= '0;
      for (int r = 0; r < MAX_RUN; r++) begin
        prev_start[r] <= 16'd1;
      end
    end else if (adv) begin
      cur_byte   <= cur_byte_next;
      run_start  <= run_start_next;
      run_cnt    <= run_cnt_next;
      pos        <= pos_next;
      seg_idx    <= seg_idx_next;
      prev_start <= prev_start_next;
    end
  end

  // --------------------------------------------------------------------
  // stage b: histogram memory, read-modify-write with forwarding
  // --------------------------------------------------------------------
  logic                   ram_we;
  logic [HIST_AW-1:0]     ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   fwd_valid;
  logic [HIST_AW-1:0]     fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [COUNT_WIDTH-1:0] bin_val;
  logic [COUNT_WIDTH-1:0] bin_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_op <= '0;
    end else if (adv) begin
      b_op <= b_op_next;
    end
  end

  // the memory returns pre-write data when the same bin was written last cycle
  assign bin_val = (fwd_valid && (fwd_addr == b_op.addr)) ? fwd_data : ram_rdata;
  assign bin_inc = (bin_val == COUNT_MAX) ? bin_val : bin_val + COUNT_WIDTH'(1);

  always_comb begin
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = adv && b_op.inc;
      ram_waddr = b_op.addr;
      ram_wdata = bin_inc;
    end
  end

  rgh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (b_op_next.addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (clr_active) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= b_op.inc;
    end
    if (adv) begin
      fwd_addr <= b_op.addr;
      fwd_data <= bin_inc;
    end
  end

  // clearing pass over the histogram after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (32'(clr_addr) == HIST_DEPTH - 1) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + HIST_AW'(1);
    end
  end

  // --------------------------------------------------------------------
  // stage c: result register with a one-entry skid register behind it
  // --------------------------------------------------------------------
  logic [15:0] result_data;

  assign result_data = b_op.rd_ok ? 16'(bin_val) : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tvalid && !m_axis_tready) begin
      // output held: a new result goes to the skid register
      if (adv && b_op.rd) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_axis_tvalid <= 1'b1;
      skid_valid    <= 1'b0;
    end else begin
      m_axis_tvalid <= b_op.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && !m_axis_tready) begin
      if (adv && b_op.rd) begin
        skid_data <= result_data;
      end
    end else if (skid_valid) begin
      m_axis_tdata <= skid_data;
    end else begin
      m_axis_tdata <= result_data;
    end
  end

  // --------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------
  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_axis_tready)
    else $error("input accepted during histogram clearing pass");

  a_write_in_range : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(ram_waddr) < HIST_DEPTH))
    else $error("histogram write outside the memory");

  a_seg_idx_bound : assert property (@(posedge clk) disable iff (rst)
    32'(seg_idx) <= NUM_SEGMENTS)
    else $error("segment index past the last segment");

  a_done_pos_zero : assert property (@(posedge clk) disable iff (rst)
    (32'(seg_idx) == NUM_SEGMENTS) |-> (pos == 16'd0) && (run_cnt == '0))
    else $error("stream state moved after the last segment");

  a_run_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    32'(run_cnt) <= MAX_RUN + 1)
    else $error("run count past saturation");

  a_no_inc_on_read : assert property (@(posedge clk) disable iff (rst)
    !(b_op.inc && b_op.rd))
    else $error("one transaction both reads and increments");

endmodule

`default_nettype wire
